[rtl/stl_pkg.sv]
`timescale 1ns / 1ps

package stl_pkg;

    localparam int unsigned MaxRes = 3;

    typedef logic [3:0] kind_t;

    localparam kind_t K_BYTE    = 4'd0;
    localparam kind_t K_END     = 4'd1;
    localparam kind_t K_NEWLINE = 4'd2;
    localparam kind_t K_SEMI    = 4'd3;
    localparam kind_t K_AND     = 4'd4;
    localparam kind_t K_OR      = 4'd5;
    localparam kind_t K_PIPE    = 4'd6;
    localparam kind_t K_OPEN    = 4'd7;
    localparam kind_t K_CLOSE   = 4'd8;
    localparam kind_t K_BANG    = 4'd9;
    localparam kind_t K_LESS    = 4'd10;
    localparam kind_t K_EOF     = 4'd11;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_NL    = 8'h0a;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_SEMI  = 8'h3b;
    localparam logic [7:0] C_LT    = 8'h3c;
    localparam logic [7:0] C_GT    = 8'h3e;
    localparam logic [7:0] C_BSLASH = 8'h5c;
    localparam logic [7:0] C_BTICK = 8'h60;
    localparam logic [7:0] C_BAR   = 8'h7c;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_WORD = 5'b00010,
        MODE_AMP  = 5'b00100,
        MODE_BAR  = 5'b01000,
        MODE_SPEC = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_out;
        kind_t      kind;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t [MaxRes-1:0] res;
    } bundle_t;

    typedef struct packed {
        logic  hit;
        res_t  res;
        mode_t mode;
    } tstart_t;

    typedef struct packed {
        bundle_t bnd;
        mode_t   mode;
    } lex_out_t;

    function automatic res_t mk_res(kind_t k, logic [7:0] b);
        res_t r;
        r.kind     = k;
        r.byte_out = b;
        return r;
    endfunction

    function automatic logic plain_word_byte(logic [7:0] c);
        logic p;
        p = !(c == C_NUL || c == C_BAR || c == C_AMP || c == C_SEMI || c == C_LT
              || c == C_GT || c == C_LPAR || c == C_RPAR || c == C_DOLLAR
              || c == C_BTICK || c == C_BSLASH || c == C_DQUOTE || c == C_SQUOTE
              || c == C_SPACE || c == C_TAB || c == C_NL);
        return p;
    endfunction

    // byte seen at a token start: at most one result
    function automatic tstart_t token_start(logic [7:0] c);
        tstart_t t;
        t.hit  = 1'b1;
        t.res  = mk_res(K_BYTE, c);
        t.mode = MODE_IDLE;
        priority if (c == C_SPACE) begin
            t.hit = 1'b0;
        end else if (c == C_NUL) begin
            t.res = mk_res(K_EOF, 8'h00);
        end else if (c == C_NL) begin
            t.res = mk_res(K_NEWLINE, 8'h00);
        end else if (c == C_SEMI) begin
            t.res = mk_res(K_SEMI, 8'h00);
        end else if (c == C_LPAR) begin
            t.res = mk_res(K_OPEN, 8'h00);
        end else if (c == C_RPAR) begin
            t.res = mk_res(K_CLOSE, 8'h00);
        end else if (c == C_BANG) begin
            t.res = mk_res(K_BANG, 8'h00);
        end else if (c == C_LT) begin
            t.res = mk_res(K_LESS, 8'h00);
        end else if (c == C_AMP) begin
            t.hit  = 1'b0;
            t.mode = MODE_AMP;
        end else if (c == C_BAR) begin
            t.hit  = 1'b0;
            t.mode = MODE_BAR;
        end else if (c == C_GT || c == C_DOLLAR || c == C_BTICK || c == C_BSLASH
                     || c == C_DQUOTE || c == C_SQUOTE || c == C_TAB) begin
            t.mode = MODE_SPEC;
        end else begin
            t.mode = MODE_WORD;
        end
        return t;
    endfunction

endpackage

[rtl/stl_lex.sv]
`timescale 1ns / 1ps

module stl_lex
    import stl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_ch,
    input  logic        ser_ready,
    output logic        bnd_load,
    output bundle_t     bnd
);

    logic       valid_reg, valid_next;
    logic [7:0] ch_reg;
    mode_t      mode_reg, mode_next;
    lex_out_t   dec;
    tstart_t    ts;
    logic       advance;

    always_comb begin
        ts       = token_start(ch_reg);
        dec      = '0;
        dec.mode = MODE_IDLE;
        unique case (mode_reg)
            MODE_WORD: begin
                if (plain_word_byte(ch_reg)) begin
                    dec.bnd.res[0] = mk_res(K_BYTE, ch_reg);
                    dec.bnd.cnt    = 2'd1;
                    dec.mode       = MODE_WORD;
                end else begin
                    dec.bnd.res[0] = mk_res(K_END, 8'h00);
                    dec.bnd.res[1] = ts.res;
                    dec.bnd.cnt    = 2'd1 + {1'b0, ts.hit};
                    dec.mode       = ts.mode;
                end
            end
            MODE_SPEC: begin
                dec.bnd.res[0] = mk_res(K_END, 8'h00);
                dec.bnd.res[1] = ts.res;
                dec.bnd.cnt    = 2'd1 + {1'b0, ts.hit};
                dec.mode       = ts.mode;
            end
            MODE_AMP: begin
                if (ch_reg == C_AMP) begin
                    dec.bnd.res[0] = mk_res(K_AND, 8'h00);
                    dec.bnd.cnt    = 2'd1;
                end else begin
                    // lone ampersand is a one-byte word
                    dec.bnd.res[0] = mk_res(K_BYTE, C_AMP);
                    dec.bnd.res[1] = mk_res(K_END, 8'h00);
                    dec.bnd.res[2] = ts.res;
                    dec.bnd.cnt    = 2'd2 + {1'b0, ts.hit};
                    dec.mode       = ts.mode;
                end
            end
            MODE_BAR: begin
                if (ch_reg == C_BAR) begin
                    dec.bnd.res[0] = mk_res(K_OR, 8'h00);
                    dec.bnd.cnt    = 2'd1;
                end else begin
                    dec.bnd.res[0] = mk_res(K_PIPE, 8'h00);
                    dec.bnd.res[1] = ts.res;
                    dec.bnd.cnt    = 2'd1 + {1'b0, ts.hit};
                    dec.mode       = ts.mode;
                end
            end
            default: begin
                dec.bnd.res[0] = ts.res;
                dec.bnd.cnt    = {1'b0, ts.hit};
                dec.mode       = ts.mode;
            end
        endcase
    end

    // an item that yields nothing moves on without the serializer
    assign advance  = valid_reg && (dec.bnd.cnt == 2'd0 || ser_ready);
    assign in_ready = !valid_reg || advance;
    assign bnd_load = advance && (dec.bnd.cnt != 2'd0);
    assign bnd      = dec.bnd;

    always_comb begin
        valid_next = valid_reg;
        mode_next  = mode_reg;
        if (advance) begin
            valid_next = 1'b0;
            mode_next  = dec.mode;
        end
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mode_reg  <= MODE_IDLE;
        end else begin
            valid_reg <= valid_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ch_reg <= in_ch;
        end
    end

endmodule

[rtl/stl_ser.sv]
`timescale 1ns / 1ps

module stl_ser
    import stl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        bnd_load,
    input  bundle_t     bnd,
    output logic        ser_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_res,
    output logic        out_last
);

    logic [1:0]        cnt_reg, cnt_next;
    res_t [MaxRes-1:0] res_reg, res_next;
    logic              take;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && out_ready;
    assign ser_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_res   = res_reg[0];
    assign out_last  = (cnt_reg == 2'd1);

    always_comb begin
        cnt_next = cnt_reg;
        res_next = res_reg;
        if (take) begin
            cnt_next   = cnt_reg - 2'd1;
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
        end
        if (bnd_load) begin
            cnt_next = bnd.cnt;
            res_next = bnd.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        bnd_load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready)))
        else $error("bundle loaded over undelivered results");

    a_load_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        bnd_load |-> bnd.cnt != 2'd0)
        else $error("empty bundle loaded");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> ($stable(cnt_reg) && $stable(res_reg[0])))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> cnt_reg == 2'd0)
        else $error("results pending after reset");

endmodule

[rtl/shell_token_lexer_top.sv]
`timescale 1ns / 1ps

// shell token lexer
// s_ channel takes one command-line byte per item in s_tdata; a zero byte
// ends the line and yields eof, after which a new line may follow at once.
// m_ channel gives one token item per transfer: m_tdata[3:0] kind,
// m_tdata[11:4] byte_out (word bytes only); m_tlast marks the final item
// caused by one input byte. a byte may cause zero to three items.
// m_tvalid rises once the accepted byte has passed the input register
// and then the result register; the result register takes a new bundle
// only once the previous one has drained or is on its last item.
// throughput: one byte per cycle while m_tready is high, as long as each
// byte gives at most one item; a byte giving more items holds the result
// register until they drain, one item per cycle while m_tready is high.
// reset (aresetn low, synchronous) empties both registers and returns the
// lexer to the state between tokens.
// when m_tready is low the current item holds; the input register keeps
// one byte, then s_tready drops until results drain.
module shell_token_lexer_top
    import stl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] kind, [11:4] byte_out, [15:12] zero
    output logic        m_tlast
);

    logic    ser_ready;
    logic    bnd_load;
    bundle_t bnd;
    res_t    out_res;

    stl_lex u_lex (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ch     (s_tdata),
        .ser_ready (ser_ready),
        .bnd_load  (bnd_load),
        .bnd       (bnd)
    );

    stl_ser u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bnd_load  (bnd_load),
        .bnd       (bnd),
        .ser_ready (ser_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'h0, out_res.byte_out, out_res.kind};

endmodule
